// ===== design/mvm_pkg.sv =====
// ----------------------------------------------------------------------------
// mvm_pkg
// Shared types, codes and widths of the matrix-vector multiply core.
// ----------------------------------------------------------------------------
package mvm_pkg;

  localparam int DEF_MAX_ROWS = 16;
  localparam int DEF_MAX_COLS = 16;
  localparam int QUEUE_DEPTH  = 4;

  localparam int VALUE_W = 16;
  localparam int PROD_W  = 32;
  localparam int SUM_W   = 40;
  localparam int CFG_W   = 5;
  localparam int CFG_AW  = 4;
  localparam int APB_DW  = 32;
  localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

  localparam logic [1:0] OP_WR_MAT = 2'd0;
  localparam logic [1:0] OP_WR_VEC = 2'd1;
  localparam logic [1:0] OP_MUL    = 2'd2;

  localparam logic [1:0] CMD_MAT = 2'd0;
  localparam logic [1:0] CMD_VEC = 2'd1;
  localparam logic [1:0] CMD_MUL = 2'd2;
  localparam logic [1:0] CMD_MIS = 2'd3;

  localparam logic [1:0] REG_ROWS = 2'd0;
  localparam logic [1:0] REG_COLS = 2'd1;
  localparam logic [1:0] REG_VLEN = 2'd2;

  typedef struct packed {
    logic [CFG_W-1:0] rows;
    logic [CFG_W-1:0] cols;
    logic [CFG_W-1:0] vlen;
  } cfg_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [3:0]         row;
    logic [3:0]         col;
    logic [VALUE_W-1:0] value;
  } cmd_t;

  typedef struct packed {
    logic       valid;
    logic       first;
    logic       use_prod;
    logic       last_col;
    logic       last;
    logic       mismatch;
    logic [3:0] row;
  } slot_t;

endpackage

// ===== design/mvm_ram.sv =====
// ----------------------------------------------------------------------------
// mvm_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module mvm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/mvm_front.sv =====
// ----------------------------------------------------------------------------
// mvm_front
// Accepts command words, drops ignored ones and classifies the rest.
// ----------------------------------------------------------------------------
module mvm_front import mvm_pkg::*; #(
  parameter int MAX_ROWS = DEF_MAX_ROWS,
  parameter int MAX_COLS = DEF_MAX_COLS
) (
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         operation,
  input  logic [3:0]         row_sel,
  input  logic [3:0]         col_sel,
  input  logic [VALUE_W-1:0] value,
  input  cfg_t               cfg,
  input  logic               q_full,
  output logic               q_push,
  output cmd_t               q_data
);

  logic accept;
  logic row_ok;
  logic col_ok;
  logic keep;

  assign busy   = q_full;
  assign accept = start && !q_full;
  assign row_ok = 32'(row_sel) < 32'(MAX_ROWS);
  assign col_ok = 32'(col_sel) < 32'(MAX_COLS);

  always_comb begin
    keep         = 1'b0;
    q_data.kind  = CMD_MAT;
    q_data.row   = row_sel;
    q_data.col   = col_sel;
    q_data.value = value;
    case (operation)
      OP_WR_MAT: begin
        keep        = row_ok && col_ok;
        q_data.kind = CMD_MAT;
      end
      OP_WR_VEC: begin
        keep        = col_ok;
        q_data.kind = CMD_VEC;
      end
      OP_MUL: begin
        keep        = 1'b1;
        q_data.kind = (cfg.cols != cfg.vlen) ? CMD_MIS : CMD_MUL;
      end
      default: begin
        keep        = 1'b0;
        q_data.kind = CMD_MAT;
      end
    endcase
  end

  assign q_push = accept && keep;

endmodule

// ===== design/mvm_queue.sv =====
// ----------------------------------------------------------------------------
// mvm_queue
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
module mvm_queue import mvm_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_data,
  input  logic pop,
  output cmd_t pop_data,
  output logic full,
  output logic empty
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  cmd_t          entry [QUEUE_DEPTH];
  logic [PW-1:0] wptr;
  logic [PW-1:0] rptr;
  logic [CW-1:0] count;

  assign full     = count == CW'(QUEUE_DEPTH);
  assign empty    = count == '0;
  assign pop_data = entry[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) full |-> !push)
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) empty |-> !pop)
    else $error("queue pop while empty");

endmodule

// ===== design/mvm_back.sv =====
// ----------------------------------------------------------------------------
// mvm_back
// Executes queued commands: store writes, mismatch words and a pipelined row-by-row MAC.
// ----------------------------------------------------------------------------
module mvm_back import mvm_pkg::*; #(
  parameter int MAX_ROWS = DEF_MAX_ROWS,
  parameter int MAX_COLS = DEF_MAX_COLS
) (
  input  logic               clk,
  input  logic               rst,
  input  cfg_t               cfg,
  input  logic               q_empty,
  input  cmd_t               q_data,
  output logic               q_pop,
  output logic               result_valid,
  output logic [3:0]         row_index,
  output logic [SUM_W-1:0]   dot_sum,
  output logic               mismatch,
  output logic               last
);

  localparam int MAT_DEPTH = MAX_ROWS * MAX_COLS;
  localparam int MAW       = (MAT_DEPTH > 1) ? $clog2(MAT_DEPTH) : 1;
  localparam int VAW       = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int ROW_LIMIT = (MAX_ROWS < 16) ? MAX_ROWS : 16;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic             state;
  logic [3:0]       row_cnt;
  logic [CFG_W-1:0] col_cnt;
  logic [MAW-1:0]   row_base;
  logic [CFG_W-1:0] rows_run;
  logic [CFG_W-1:0] cols_run;

  logic [CFG_W-1:0] rows_eff;
  logic [CFG_W-1:0] cols_eff;
  logic             start_run;
  logic             mis_pop;
  logic             run;
  logic             last_col;
  logic             last_row;

  logic [MAW-1:0]     mat_waddr;
  logic [MAW-1:0]     mat_raddr;
  logic [VAW-1:0]     vec_waddr;
  logic [VAW-1:0]     vec_raddr;
  logic [VALUE_W-1:0] mat_rdata;
  logic [VALUE_W-1:0] vec_rdata;

  slot_t                     slot0;
  slot_t                     slot1;
  slot_t                     slot2;
  logic signed [PROD_W-1:0]  prod2;
  logic [SUM_W-1:0]          acc;
  logic [SUM_W-1:0]          acc_next;
  logic [SUM_W-1:0]          prod_ext;

  assign rows_eff = (cfg.rows < CFG_W'(ROW_LIMIT)) ? cfg.rows : CFG_W'(ROW_LIMIT);
  assign cols_eff = (9'(cfg.cols) < 9'(MAX_COLS)) ? cfg.cols : CFG_W'(MAX_COLS);

  assign q_pop     = (state == ST_IDLE) && !q_empty;
  assign start_run = q_pop && (q_data.kind == CMD_MUL) && (rows_eff != '0);
  assign mis_pop   = q_pop && (q_data.kind == CMD_MIS);
  assign run       = state == ST_RUN;

  assign last_col = (cols_run == '0) || (col_cnt == cols_run - 1'b1);
  assign last_row = {1'b0, row_cnt} == rows_run - 1'b1;

  assign mat_waddr = MAW'(32'(q_data.row) * MAX_COLS + 32'(q_data.col));
  assign vec_waddr = VAW'(q_data.col);
  assign mat_raddr = row_base + MAW'(col_cnt);
  assign vec_raddr = VAW'(col_cnt);

  mvm_ram #(.WIDTH(VALUE_W), .DEPTH(MAT_DEPTH)) u_mat_ram (
    .clk   (clk),
    .we    (q_pop && (q_data.kind == CMD_MAT)),
    .waddr (mat_waddr),
    .wdata (q_data.value),
    .raddr (mat_raddr),
    .rdata (mat_rdata)
  );

  mvm_ram #(.WIDTH(VALUE_W), .DEPTH(MAX_COLS)) u_vec_ram (
    .clk   (clk),
    .we    (q_pop && (q_data.kind == CMD_VEC)),
    .waddr (vec_waddr),
    .wdata (q_data.value),
    .raddr (vec_raddr),
    .rdata (vec_rdata)
  );

  always_comb begin
    slot0.valid    = run || mis_pop;
    slot0.first    = mis_pop || (col_cnt == '0);
    slot0.use_prod = run && (cols_run != '0);
    slot0.last_col = mis_pop || last_col;
    slot0.last     = mis_pop || (last_col && last_row);
    slot0.mismatch = mis_pop;
    slot0.row      = run ? row_cnt : 4'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE: begin
          if (start_run) begin
            state <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (last_col && last_row) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (start_run) begin
      row_cnt  <= '0;
      col_cnt  <= '0;
      row_base <= '0;
      rows_run <= rows_eff;
      cols_run <= cols_eff;
    end else if (run) begin
      if (last_col) begin
        col_cnt  <= '0;
        row_cnt  <= row_cnt + 1'b1;
        row_base <= row_base + MAW'(MAX_COLS);
      end else begin
        col_cnt <= col_cnt + 1'b1;
      end
    end
  end

  // advance the MAC pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      slot1.valid  <= 1'b0;
      slot2.valid  <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      slot1.valid  <= slot0.valid;
      slot2.valid  <= slot1.valid;
      result_valid <= slot2.valid && slot2.last_col;
    end
    slot1.first    <= slot0.first;
    slot1.use_prod <= slot0.use_prod;
    slot1.last_col <= slot0.last_col;
    slot1.last     <= slot0.last;
    slot1.mismatch <= slot0.mismatch;
    slot1.row      <= slot0.row;
    slot2.first    <= slot1.first;
    slot2.use_prod <= slot1.use_prod;
    slot2.last_col <= slot1.last_col;
    slot2.last     <= slot1.last;
    slot2.mismatch <= slot1.mismatch;
    slot2.row      <= slot1.row;
    prod2          <= $signed(mat_rdata) * $signed(vec_rdata);
  end

  assign prod_ext = {{(SUM_W - PROD_W){prod2[PROD_W-1]}}, prod2};
  assign acc_next = (slot2.first ? '0 : acc) + (slot2.use_prod ? prod_ext : '0);

  always_ff @(posedge clk) begin
    if (slot2.valid) begin
      acc <= acc_next;
    end
    if (slot2.valid && slot2.last_col) begin
      row_index <= slot2.row;
      dot_sum   <= acc_next;
      mismatch  <= slot2.mismatch;
      last      <= slot2.last;
    end
  end

  a_mis_word: assert property (@(posedge clk) disable iff (rst)
      result_valid && mismatch |-> last && (row_index == 4'd0) && (dot_sum == '0))
    else $error("mismatch word malformed");
  a_run_ends: assert property (@(posedge clk) disable iff (rst)
      run && slot0.last |=> state == ST_IDLE)
    else $error("run did not end after last row");
  a_row_out: assert property (@(posedge clk) disable iff (rst)
      slot2.valid && slot2.last_col |=> result_valid)
    else $error("finished row not delivered");

endmodule

// ===== design/matrix_vector_multiply_core.sv =====
// ----------------------------------------------------------------------------
// matrix_vector_multiply_core
// Loads matrix and vector elements, then streams one Q24.16 dot product per row.
// ----------------------------------------------------------------------------
// Channel   Handshake                         Payload
// command   start in, busy out                operation, row_sel, col_sel, value
// result    result_valid out, one cycle       row_index, dot_sum, mismatch, last
// config    psel, penable, pwrite, pready     paddr, pwdata, prdata
//
// A load word is written to its store when popped; a four-word queue lets the front take
// one word per cycle while the back end is busy, and busy is high while it is full.
// A multiply is popped, then issues one MAC per row and column (one per row if cols
// is zero) through the two store read ports; a mismatch issues one result word, a
// zero-row multiply none. Results pass the read, product and output registers; the
// receiver cannot stall them. Reset sets all three registers to 16; the stores are not cleared.
// ----------------------------------------------------------------------------
module matrix_vector_multiply_core import mvm_pkg::*; #(
  parameter int MAX_ROWS = DEF_MAX_ROWS,
  parameter int MAX_COLS = DEF_MAX_COLS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         operation,
  input  logic [3:0]         row_sel,
  input  logic [3:0]         col_sel,
  input  logic [VALUE_W-1:0] value,
  output logic               result_valid,
  output logic [3:0]         row_index,
  output logic [SUM_W-1:0]   dot_sum,
  output logic               mismatch,
  output logic               last,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [CFG_AW-1:0]  paddr,
  input  logic [APB_DW-1:0]  pwdata,
  output logic [APB_DW-1:0]  prdata,
  output logic               pready
);

  cfg_t cfg;
  logic cfg_we;
  logic q_full;
  logic q_empty;
  logic q_push;
  logic q_pop;
  cmd_t q_in;
  cmd_t q_out;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.rows <= CFG_RESET;
      cfg.cols <= CFG_RESET;
      cfg.vlen <= CFG_RESET;
    end else if (cfg_we) begin
      case (paddr[3:2])
        REG_ROWS: cfg.rows <= pwdata[CFG_W-1:0];
        REG_COLS: cfg.cols <= pwdata[CFG_W-1:0];
        REG_VLEN: cfg.vlen <= pwdata[CFG_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_ROWS: prdata = APB_DW'(cfg.rows);
      REG_COLS: prdata = APB_DW'(cfg.cols);
      REG_VLEN: prdata = APB_DW'(cfg.vlen);
      default:  prdata = '0;
    endcase
  end

  mvm_front #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS)) u_front (
    .start     (start),
    .busy      (busy),
    .operation (operation),
    .row_sel   (row_sel),
    .col_sel   (col_sel),
    .value     (value),
    .cfg       (cfg),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_data    (q_in)
  );

  mvm_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .pop_data  (q_out),
    .full      (q_full),
    .empty     (q_empty)
  );

  mvm_back #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS)) u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .q_empty      (q_empty),
    .q_data       (q_out),
    .q_pop        (q_pop),
    .result_valid (result_valid),
    .row_index    (row_index),
    .dot_sum      (dot_sum),
    .mismatch     (mismatch),
    .last         (last)
  );

endmodule

// ===== dv/tb_matrix_vector_multiply_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_matrix_vector_multiply_core
// Self-checking bench for the matrix-vector multiply core. Element loads and
// multiply requests go in over the start/busy port, with random gaps. Register
// settings go in over APB and are read back. A scoreboard keeps its own copy of
// both stores and the registers, works out every dot product, mismatch and
// last flag, and checks each result word in order as it leaves the core.
// ----------------------------------------------------------------------------
import mvm_pkg::*;

typedef struct {
  logic [3:0]       row;
  logic [SUM_W-1:0] sum;
  logic             mis;
  logic             fin;
} dot_word_t;

class mvm_scoreboard;
  logic [VALUE_W-1:0] mat_copy [16][16];
  logic [VALUE_W-1:0] vec_copy [16];
  logic [CFG_W-1:0]   rows_reg;
  logic [CFG_W-1:0]   cols_reg;
  logic [CFG_W-1:0]   vlen_reg;
  dot_word_t          expected_dots [$];
  int                 errors;
  int                 dots_checked;

  function new();
    rows_reg     = CFG_RESET;
    cols_reg     = CFG_RESET;
    vlen_reg     = CFG_RESET;
    errors       = 0;
    dots_checked = 0;
  endfunction

  task report_mismatch(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    errors++;
  endtask

  function void set_reg(input logic [1:0] idx, input logic [CFG_W-1:0] val);
    case (idx)
      REG_ROWS: rows_reg = val;
      REG_COLS: cols_reg = val;
      REG_VLEN: vlen_reg = val;
      default: ;
    endcase
  endfunction

  function void note_word(input logic [1:0] op, input logic [3:0] row, input logic [3:0] col,
                          input logic [VALUE_W-1:0] val);
    dot_word_t d;
    longint    acc;
    int        nrows;
    int        ncols;
    case (op)
      OP_WR_MAT: mat_copy[row][col] = val;
      OP_WR_VEC: vec_copy[col] = val;
      OP_MUL: begin
        if (cols_reg != vlen_reg) begin
          d.row = '0;
          d.sum = '0;
          d.mis = 1'b1;
          d.fin = 1'b1;
          expected_dots.push_back(d);
        end else begin
          nrows = (rows_reg > 16) ? 16 : int'(rows_reg);
          ncols = (cols_reg > 16) ? 16 : int'(cols_reg);
          for (int i = 0; i < nrows; i++) begin
            acc = 0;
            for (int j = 0; j < ncols; j++)
              acc += longint'($signed(mat_copy[i][j])) * longint'($signed(vec_copy[j]));
            d.row = i[3:0];
            d.sum = acc[SUM_W-1:0];
            d.mis = 1'b0;
            d.fin = (i == nrows - 1);
            expected_dots.push_back(d);
          end
        end
      end
      default: ;
    endcase
  endfunction

  task check_dot(input logic [3:0] row, input logic [SUM_W-1:0] sum, input logic mis,
                 input logic fin);
    dot_word_t e;
    if (expected_dots.size() == 0) begin
      report_mismatch($sformatf("unexpected result row %0d sum %h", row, sum));
    end else begin
      e = expected_dots.pop_front();
      dots_checked++;
      if (row !== e.row)
        report_mismatch($sformatf("row_index %0d, want %0d", row, e.row));
      if (sum !== e.sum)
        report_mismatch($sformatf("dot_sum %h, want %h (row %0d)", sum, e.sum, e.row));
      if (mis !== e.mis)
        report_mismatch($sformatf("mismatch %b, want %b (row %0d)", mis, e.mis, e.row));
      if (fin !== e.fin)
        report_mismatch($sformatf("last %b, want %b (row %0d)", fin, e.fin, e.row));
    end
  endtask
endclass

module tb_matrix_vector_multiply_core;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int ITEMS_TARGET = 450;
  localparam int NOGAP_FROM   = 120;
  localparam int NOGAP_TO     = 220;
  localparam int SETTLE_CYCLES = 64;
  localparam int DRAIN_LIMIT  = 20000;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic [1:0]         operation = OP_WR_MAT;
  logic [3:0]         row_sel = '0;
  logic [3:0]         col_sel = '0;
  logic [VALUE_W-1:0] value = '0;
  logic               result_valid;
  logic [3:0]         row_index;
  logic [SUM_W-1:0]   dot_sum;
  logic               mismatch;
  logic               last;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [CFG_AW-1:0]  paddr = '0;
  logic [APB_DW-1:0]  pwdata = '0;
  logic [APB_DW-1:0]  prdata;
  logic               pready;

  mvm_scoreboard sb = new();
  int words_sent = 0;
  int multiplies_sent = 0;
  int settings_applied = 0;

  matrix_vector_multiply_core dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .operation    (operation),
    .row_sel      (row_sel),
    .col_sel      (col_sel),
    .value        (value),
    .result_valid (result_valid),
    .row_index    (row_index),
    .dot_sum      (dot_sum),
    .mismatch     (mismatch),
    .last         (last),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && result_valid)
      sb.check_dot(row_index, dot_sum, mismatch, last);
  end

  initial begin
    #10_000_000;
    $display("tb_matrix_vector_multiply_core NOT OK");
    $finish;
  end

  function automatic logic [VALUE_W-1:0] pick_value(input int extreme_pct);
    int p;
    p = $urandom_range(0, 99);
    if (p < extreme_pct / 2)
      return 16'h8000;
    if (p < extreme_pct)
      return 16'h7fff;
    return VALUE_W'($urandom());
  endfunction

  function automatic int pick_dim();
    int p;
    p = $urandom_range(0, 99);
    if (p < 5)
      return 0;
    if (p < 75)
      return $urandom_range(1, 4);
    if (p < 90)
      return $urandom_range(5, 16);
    return $urandom_range(17, 31);
  endfunction

  task automatic send_word(input logic [1:0] op, input logic [3:0] row, input logic [3:0] col,
                           input logic [VALUE_W-1:0] val);
    bit gaps_on;
    gaps_on = (words_sent < NOGAP_FROM) || (words_sent >= NOGAP_TO);
    if (gaps_on && $urandom_range(0, 99) < 24) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    start     <= 1'b1;
    operation <= op;
    row_sel   <= row;
    col_sel   <= col;
    value     <= val;
    do @(posedge clk); while (busy);
    sb.note_word(op, row, col, val);
    if (op != OP_UNUSED)
      words_sent++;
    if (op == OP_MUL)
      multiplies_sent++;
  endtask

  task automatic send_multiply();
    send_word(OP_MUL, 4'($urandom()), 4'($urandom()), VALUE_W'($urandom()));
  endtask

  task automatic apb_xfer(input logic wr, input logic [1:0] idx, input logic [APB_DW-1:0] wdata,
                          output logic [APB_DW-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
  endtask

  task automatic apb_idle();
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic check_reg(input logic [1:0] idx, input logic [CFG_W-1:0] want);
    logic [APB_DW-1:0] rd;
    apb_xfer(1'b0, idx, '0, rd);
    if (rd !== APB_DW'(want))
      sb.report_mismatch($sformatf("register %0d reads %h, want %h", idx, rd, want));
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [CFG_W-1:0] val);
    logic [APB_DW-1:0] data;
    logic [APB_DW-1:0] rd;
    data = ($urandom_range(0, 3) == 0) ? APB_DW'($urandom()) : '0;
    data[CFG_W-1:0] = val;
    apb_xfer(1'b1, idx, data, rd);
    sb.set_reg(idx, data[CFG_W-1:0]);
    check_reg(idx, val);
  endtask

  // hold until every expected word is out and the load queue has emptied
  task automatic drain_and_settle();
    start <= 1'b0;
    while (sb.expected_dots.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apply_setting(input int r, input int c, input int v);
    drain_and_settle();
    cfg_write(REG_ROWS, r[CFG_W-1:0]);
    cfg_write(REG_COLS, c[CFG_W-1:0]);
    cfg_write(REG_VLEN, v[CFG_W-1:0]);
    apb_idle();
    settings_applied++;
  endtask

  task automatic run_phase(input int r, input int c, input int v, input int n_mix,
                           input int extreme_pct);
    int re;
    int ce;
    int p;
    apply_setting(r, c, v);
    re = (r > 16) ? 16 : r;
    ce = (c > 16) ? 16 : c;
    for (int i = 0; i < re; i++)
      for (int j = 0; j < ce; j++)
        send_word(OP_WR_MAT, i[3:0], j[3:0], pick_value(extreme_pct));
    for (int j = 0; j < ce; j++)
      send_word(OP_WR_VEC, 4'($urandom()), j[3:0], pick_value(extreme_pct));
    repeat (n_mix) begin
      p = $urandom_range(0, 99);
      if (p < 40)
        send_multiply();
      else if (p < 65)
        send_word(OP_WR_MAT, 4'($urandom()), 4'($urandom()), pick_value(extreme_pct));
      else if (p < 85)
        send_word(OP_WR_VEC, 4'($urandom()), 4'($urandom()), pick_value(extreme_pct));
      else
        send_word(OP_UNUSED, 4'($urandom()), 4'($urandom()), VALUE_W'($urandom()));
    end
    send_multiply();
  endtask

  initial begin
    int phase_no;
    int r;
    int c;
    int v;
    int waited;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    check_reg(REG_ROWS, CFG_RESET);
    check_reg(REG_COLS, CFG_RESET);
    check_reg(REG_VLEN, CFG_RESET);
    apb_idle();

    apply_setting(2, 2, 2);
    send_word(OP_WR_MAT, 4'd0, 4'd0, 16'h7fff);
    send_word(OP_WR_MAT, 4'd0, 4'd1, 16'h8000);
    send_word(OP_WR_MAT, 4'd1, 4'd0, 16'h8000);
    send_word(OP_WR_MAT, 4'd1, 4'd1, 16'h8000);
    send_word(OP_WR_VEC, 4'd0, 4'd0, 16'h8000);
    send_word(OP_WR_VEC, 4'd15, 4'd1, 16'h8000);
    send_word(OP_UNUSED, 4'd15, 4'd15, 16'hffff);
    send_multiply();
    send_word(OP_WR_MAT, 4'd15, 4'd15, 16'hffff);
    send_word(OP_WR_VEC, 4'd0, 4'd15, 16'h0000);
    send_word(OP_WR_VEC, 4'd0, 4'd0, 16'h7fff);
    send_word(OP_WR_VEC, 4'd0, 4'd1, 16'h0001);
    send_word(OP_WR_MAT, 4'd1, 4'd1, 16'h0000);
    send_multiply();
    apply_setting(2, 2, 3);
    send_multiply();
    apply_setting(0, 2, 2);
    send_multiply();
    apply_setting(1, 0, 0);
    send_multiply();
    apply_setting(31, 0, 0);
    send_multiply();

    phase_no = 0;
    while (words_sent < ITEMS_TARGET) begin
      if (phase_no == 1) begin
        r = ($urandom_range(0, 1) == 0) ? 16 : 31;
        c = ($urandom_range(0, 1) == 0) ? 16 : 31;
        run_phase(r, c, c, 10, 50);
      end else begin
        r = pick_dim();
        c = pick_dim();
        if (((r > 16) ? 16 : r) * ((c > 16) ? 16 : c) > 48)
          r = $urandom_range(1, 3);
        v = ($urandom_range(0, 99) < 80) ? c : $urandom_range(0, 31);
        run_phase(r, c, v, $urandom_range(8, 20), 20);
      end
      phase_no++;
    end

    start <= 1'b0;
    waited = 0;
    while (sb.expected_dots.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.expected_dots.size() != 0)
      sb.report_mismatch($sformatf("%0d expected results never came",
                                   sb.expected_dots.size()));
    $display("Covered %0d load and multiply words (%0d multiplies) over %0d register settings,",
             words_sent, multiplies_sent, settings_applied);
    $display("%0d result words checked, %0d errors.", sb.dots_checked, sb.errors);
    if (sb.errors == 0)
      $display("tb_matrix_vector_multiply_core OK");
    else
      $display("tb_matrix_vector_multiply_core NOT OK");
    $finish;
  end

endmodule
